### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion shorthands shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BFSA_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("check failed");

// next-cycle implication, disabled while reset is low
`define BFSA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### hw/rtl/bfsa_pkg.sv
// ----------------------------------------------------------------------------
// bfsa_pkg
// shared constants and types of the best-fit segment allocator
// ----------------------------------------------------------------------------
package bfsa_pkg;

  localparam int FREE_ENTRIES = 64;
  localparam int HEADER_BYTES = 24;
  localparam int ADDR_W       = 32;
  localparam int SIZE_W       = 24;
  localparam int IDX_W        = $clog2(FREE_ENTRIES);
  localparam int CNT_W        = $clog2(FREE_ENTRIES + 1);
  localparam int MS_W         = SIZE_W + 2;
  localparam int DATA_W       = ADDR_W + SIZE_W;
  localparam int TDATA_W      = ((DATA_W + 7) / 8) * 8;

  // command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // configuration register indexes
  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  // result status codes
  localparam logic [2:0] STAT_REUSE = 3'd0;
  localparam logic [2:0] STAT_GROW  = 3'd1;
  localparam logic [2:0] STAT_FREED = 3'd2;
  localparam logic [2:0] STAT_EXH   = 3'd3;
  localparam logic [2:0] STAT_FULL  = 3'd4;

  // one free-table entry
  typedef struct packed {
    logic [ADDR_W-1:0] hdr;
    logic [SIZE_W-1:0] size;
  } seg_t;

  // table access from the sequencer
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    seg_t             wdata;
    logic [IDX_W-1:0] raddr;
  } tbl_req_t;

endpackage

### hw/rtl/best_fit_segment_allocator.sv
// ----------------------------------------------------------------------------
// best_fit_segment_allocator
// best-fit free-list allocator with splitting, heap growth and coalescing
// ----------------------------------------------------------------------------
// channel   | direction | handshake                    | payload
// s_axis    | in        | s_axis_tvalid/s_axis_tready  | tuser cmd, tdata size/addr
// m_axis    | out       | m_axis_tvalid/m_axis_tready  | tuser status, tdata addr/size
// cfg       | in        | cfg_valid_i/cfg_ready_o      | cfg_index_i, cfg_data_i
//
// allocate: a best-fit scan over the entries that stops early on an exact fit, heap
// growth when none fits, and a shift down of the entries behind a segment taken whole
// to close the gap; free: an insert-place scan, merges with both neighbours, and an
// upward shift to open a slot. the table memory port serves one entry per cycle. table
// contents are undefined after reset and need no clearing pass. a finished
// item waits in the output register while the next item is accepted.
// ----------------------------------------------------------------------------
module best_fit_segment_allocator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: req_size [23:0], free_addr [55:24]
  input  logic [bfsa_pkg::TDATA_W-1:0]   s_axis_tdata,
  // tuser: cmd [0]
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: grant_addr [31:0], grant_size [55:32]
  output logic [bfsa_pkg::TDATA_W-1:0]   m_axis_tdata,
  // tuser: status [2:0]
  output logic [2:0]                     m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_index_i,
  input  logic [bfsa_pkg::ADDR_W-1:0]    cfg_data_i
);

  localparam int AW = bfsa_pkg::ADDR_W;
  localparam int SW = bfsa_pkg::SIZE_W;

  logic [AW-1:0]                 heap_base_q, heap_limit_q;
  logic                          res_valid, res_ready;
  logic [AW-1:0]                 res_addr;
  logic [SW-1:0]                 res_size;
  logic [2:0]                    res_status;
  logic                          out_valid_q;
  logic [bfsa_pkg::TDATA_W-1:0]  out_data_q;
  logic [2:0]                    out_user_q;
  bfsa_pkg::tbl_req_t            tbl_req;
  bfsa_pkg::seg_t                tbl_rdata;

  // configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heap_base_q  <= '0;
      heap_limit_q <= '1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bfsa_pkg::CFG_HEAP_BASE:  heap_base_q  <= cfg_data_i;
        bfsa_pkg::CFG_HEAP_LIMIT: heap_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bfsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_cmd_i     (s_axis_tuser),
    .in_size_i    (s_axis_tdata[SW-1:0]),
    .in_addr_i    (s_axis_tdata[SW+AW-1:SW]),
    .heap_base_i  (heap_base_q),
    .heap_limit_i (heap_limit_q),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_ready),
    .res_addr_o   (res_addr),
    .res_size_o   (res_size),
    .res_status_o (res_status),
    .tbl_req_o    (tbl_req),
    .tbl_rdata_i  (tbl_rdata)
  );

  bfsa_table u_table (
    .clk_i   (clk_i),
    .req_i   (tbl_req),
    .rdata_o (tbl_rdata)
  );

  // output register
  assign res_ready = !out_valid_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_data_q <= bfsa_pkg::TDATA_W'({res_size, res_addr});
      out_user_q <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

### hw/rtl/bfsa_table.sv
// ----------------------------------------------------------------------------
// bfsa_table
// free-segment table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bfsa_table (
  input  logic              clk_i,
  input  bfsa_pkg::tbl_req_t req_i,
  output bfsa_pkg::seg_t    rdata_o
);

  bfsa_pkg::seg_t mem_q [bfsa_pkg::FREE_ENTRIES];
  bfsa_pkg::seg_t rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/bfsa_ctrl.sv
// ----------------------------------------------------------------------------
// bfsa_ctrl
// sequencer: best-fit scan, ordered insert, coalescing and entry shifts
// ----------------------------------------------------------------------------
module bfsa_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_cmd_i,
  input  logic [bfsa_pkg::SIZE_W-1:0]   in_size_i,
  input  logic [bfsa_pkg::ADDR_W-1:0]   in_addr_i,
  input  logic [bfsa_pkg::ADDR_W-1:0]   heap_base_i,
  input  logic [bfsa_pkg::ADDR_W-1:0]   heap_limit_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output logic [bfsa_pkg::ADDR_W-1:0]   res_addr_o,
  output logic [bfsa_pkg::SIZE_W-1:0]   res_size_o,
  output logic [2:0]                    res_status_o,
  output bfsa_pkg::tbl_req_t            tbl_req_o,
  input  bfsa_pkg::seg_t                tbl_rdata_i
);

  localparam int AW = bfsa_pkg::ADDR_W;
  localparam int SW = bfsa_pkg::SIZE_W;
  localparam int IW = bfsa_pkg::IDX_W;
  localparam int CW = bfsa_pkg::CNT_W;
  localparam int MW = bfsa_pkg::MS_W;
  localparam logic [AW-1:0] HDR_A = AW'(bfsa_pkg::HEADER_BYTES);
  localparam logic [SW-1:0] HDR_S = SW'(bfsa_pkg::HEADER_BYTES);
  localparam logic [MW-1:0] HDR_M = MW'(bfsa_pkg::HEADER_BYTES);
  localparam logic [MW-1:0] SIZE_MAX_M = MW'({SW{1'b1}});

  typedef enum logic [3:0] {
    ST_IDLE, ST_A_SCAN, ST_A_PICK, ST_A_GROW1, ST_A_GROW2,
    ST_F_SCAN, ST_F_MRGR, ST_F_MRGL, ST_F_APPLY, ST_F_WRITE,
    ST_MOVE, ST_DONE
  } state_e;

  state_e          state_q, state_d;
  logic [SW-1:0]   size_q, size_d;
  logic [AW-1:0]   b_q, b_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic [AW-1:0]   used_q, used_d;
  logic [CW-1:0]   rd_q, rd_d;
  logic            pend_q, pend_d;
  logic [IW-1:0]   cidx_q, cidx_d;
  logic            best_found_q, best_found_d;
  logic [IW-1:0]   best_idx_q, best_idx_d;
  bfsa_pkg::seg_t  best_q, best_d;
  logic [CW-1:0]   p_q, p_d;
  bfsa_pkg::seg_t  prev_q, prev_d;
  logic            prev_valid_q, prev_valid_d;
  bfsa_pkg::seg_t  nxt_q, nxt_d;
  logic            nxt_valid_q, nxt_valid_d;
  logic            rm_q, rm_d;
  logic [SW-1:0]   ms_q, ms_d;
  logic            lm_q, lm_d;
  logic [SW-1:0]   lsize_q, lsize_d;
  logic [AW:0]     hsum_q, hsum_d;
  logic [IW-1:0]   mv_rd_q, mv_rd_d;
  logic [IW-1:0]   mv_last_q, mv_last_d;
  logic            mv_up_q, mv_up_d;
  logic            mv_issue_q, mv_issue_d;
  logic            mv_new_q, mv_new_d;
  logic [AW-1:0]   res_addr_q, res_addr_d;
  logic [SW-1:0]   res_size_q, res_size_d;
  logic [2:0]      res_status_q, res_status_d;

  // next-state and datapath
  always_comb begin
    logic           issue;
    logic           take;
    logic           nb_found;
    logic [SW-1:0]  nb_size;
    logic           last;
    logic [AW+1:0]  gend;
    logic [AW-1:0]  nend;
    logic [MW-1:0]  msum;
    logic [AW-1:0]  pend_addr;
    bfsa_pkg::seg_t e;

    state_d      = state_q;
    size_d       = size_q;
    b_d          = b_q;
    cnt_d        = cnt_q;
    used_d       = used_q;
    rd_d         = rd_q;
    pend_d       = pend_q;
    cidx_d       = cidx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    p_d          = p_q;
    prev_d       = prev_q;
    prev_valid_d = prev_valid_q;
    nxt_d        = nxt_q;
    nxt_valid_d  = nxt_valid_q;
    rm_d         = rm_q;
    ms_d         = ms_q;
    lm_d         = lm_q;
    lsize_d      = lsize_q;
    hsum_d       = hsum_q;
    mv_rd_d      = mv_rd_q;
    mv_last_d    = mv_last_q;
    mv_up_d      = mv_up_q;
    mv_issue_d   = mv_issue_q;
    mv_new_d     = mv_new_q;
    res_addr_d   = res_addr_q;
    res_size_d   = res_size_q;
    res_status_d = res_status_q;

    issue     = 1'b0;
    take      = 1'b0;
    nb_found  = 1'b0;
    nb_size   = '0;
    last      = 1'b0;
    gend      = '0;
    nend      = '0;
    msum      = '0;
    pend_addr = '0;
    e         = tbl_rdata_i;

    tbl_req_o.we    = 1'b0;
    tbl_req_o.waddr = '0;
    tbl_req_o.wdata = '0;
    tbl_req_o.raddr = rd_q[IW-1:0];
    in_ready_o      = 1'b0;
    res_valid_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          size_d       = in_size_i;
          b_d          = in_addr_i - HDR_A;
          rd_d         = '0;
          pend_d       = 1'b0;
          best_found_d = 1'b0;
          prev_valid_d = 1'b0;
          nxt_valid_d  = 1'b0;
          p_d          = '0;
          if (in_cmd_i == bfsa_pkg::CMD_ALLOC) begin
            state_d = (cnt_q == '0) ? ST_A_GROW1 : ST_A_SCAN;
          end else if (cnt_q == CW'(bfsa_pkg::FREE_ENTRIES)) begin
            res_addr_d   = '0;
            res_size_d   = '0;
            res_status_d = bfsa_pkg::STAT_FULL;
            state_d      = ST_DONE;
          end else begin
            state_d = (cnt_q == '0) ? ST_F_MRGR : ST_F_SCAN;
          end
        end
      end

      // best-fit scan, one entry compared per cycle
      ST_A_SCAN: begin
        issue  = (rd_q < cnt_q);
        if (issue) begin
          rd_d = rd_q + 1'b1;
        end
        pend_d = issue;
        cidx_d = rd_q[IW-1:0];
        if (pend_q) begin
          take     = (e.size >= size_q) && (!best_found_q || e.size < best_q.size);
          nb_found = best_found_q | take;
          nb_size  = take ? e.size : best_q.size;
          if (take) begin
            best_found_d = 1'b1;
            best_idx_d   = cidx_q;
            best_d       = e;
          end
          last = ({1'b0, cidx_q} == cnt_q - 1'b1);
          if ((nb_found && nb_size == size_q) || last) begin
            state_d = ST_A_PICK;
          end
        end
      end

      // split the winner's tail off or take it whole
      ST_A_PICK: begin
        if (!best_found_q) begin
          state_d = ST_A_GROW1;
        end else if ({1'b0, best_q.size} > {1'b0, size_q} + {1'b0, HDR_S}) begin
          tbl_req_o.we         = 1'b1;
          tbl_req_o.waddr      = best_idx_q;
          tbl_req_o.wdata.hdr  = best_q.hdr;
          tbl_req_o.wdata.size = best_q.size - size_q - HDR_S;
          res_addr_d   = best_q.hdr + AW'(best_q.size) + HDR_A - AW'(size_q);
          res_size_d   = size_q;
          res_status_d = bfsa_pkg::STAT_REUSE;
          state_d      = ST_DONE;
        end else begin
          res_addr_d   = best_q.hdr + HDR_A;
          res_size_d   = best_q.size;
          res_status_d = bfsa_pkg::STAT_REUSE;
          cnt_d        = cnt_q - 1'b1;
          if ({1'b0, best_idx_q} + 1'b1 < cnt_q) begin
            mv_rd_d    = best_idx_q + 1'b1;
            mv_last_d  = IW'(cnt_q - 1'b1);
            mv_up_d    = 1'b0;
            mv_issue_d = 1'b1;
            mv_new_d   = 1'b0;
            pend_d     = 1'b0;
            state_d    = ST_MOVE;
          end else begin
            state_d = ST_DONE;
          end
        end
      end

      // heap growth: header address first, then end address and limit check
      ST_A_GROW1: begin
        hsum_d  = {1'b0, heap_base_i} + {1'b0, used_q};
        state_d = ST_A_GROW2;
      end

      ST_A_GROW2: begin
        gend = {1'b0, hsum_q} + (AW+2)'(bfsa_pkg::HEADER_BYTES) + (AW+2)'(size_q);
        if (gend > {2'b00, heap_limit_i}) begin
          res_addr_d   = '0;
          res_size_d   = '0;
          res_status_d = bfsa_pkg::STAT_EXH;
        end else begin
          used_d       = used_q + HDR_A + AW'(size_q);
          res_addr_d   = hsum_q[AW-1:0] + HDR_A;
          res_size_d   = size_q;
          res_status_d = bfsa_pkg::STAT_GROW;
        end
        state_d = ST_DONE;
      end

      // find the insert position and capture both neighbours
      ST_F_SCAN: begin
        issue  = (rd_q < cnt_q);
        if (issue) begin
          rd_d = rd_q + 1'b1;
        end
        pend_d = issue;
        cidx_d = rd_q[IW-1:0];
        if (pend_q) begin
          if (e.hdr <= b_q) begin
            prev_d       = e;
            prev_valid_d = 1'b1;
            if ({1'b0, cidx_q} == cnt_q - 1'b1) begin
              p_d     = cnt_q;
              state_d = ST_F_MRGR;
            end
          end else begin
            p_d         = {1'b0, cidx_q};
            nxt_d       = e;
            nxt_valid_d = 1'b1;
            state_d     = ST_F_MRGR;
          end
        end
      end

      // merge with the following segment
      ST_F_MRGR: begin
        nend    = b_q + HDR_A + AW'(size_q);
        msum    = MW'(size_q) + MW'(nxt_q.size) + HDR_M;
        rm_d    = nxt_valid_q && (nxt_q.hdr == nend) && (msum <= SIZE_MAX_M);
        ms_d    = (nxt_valid_q && (nxt_q.hdr == nend) && (msum <= SIZE_MAX_M))
                  ? msum[SW-1:0] : size_q;
        state_d = ST_F_MRGL;
      end

      // merge with the preceding segment
      ST_F_MRGL: begin
        pend_addr = prev_q.hdr + HDR_A + AW'(prev_q.size);
        msum      = MW'(prev_q.size) + MW'(ms_q) + HDR_M;
        lm_d      = prev_valid_q && (pend_addr == b_q) && (msum <= SIZE_MAX_M);
        lsize_d   = msum[SW-1:0];
        state_d   = ST_F_APPLY;
      end

      ST_F_APPLY: begin
        res_addr_d   = '0;
        res_size_d   = '0;
        res_status_d = bfsa_pkg::STAT_FREED;
        pend_d       = 1'b0;
        if (lm_q) begin
          tbl_req_o.we         = 1'b1;
          tbl_req_o.waddr      = IW'(p_q - 1'b1);
          tbl_req_o.wdata.hdr  = prev_q.hdr;
          tbl_req_o.wdata.size = lsize_q;
          state_d              = ST_DONE;
          if (rm_q) begin
            cnt_d = cnt_q - 1'b1;
            if (p_q + 1'b1 < cnt_q) begin
              mv_rd_d    = IW'(p_q + 1'b1);
              mv_last_d  = IW'(cnt_q - 1'b1);
              mv_up_d    = 1'b0;
              mv_issue_d = 1'b1;
              mv_new_d   = 1'b0;
              state_d    = ST_MOVE;
            end
          end
        end else if (rm_q) begin
          tbl_req_o.we         = 1'b1;
          tbl_req_o.waddr      = p_q[IW-1:0];
          tbl_req_o.wdata.hdr  = b_q;
          tbl_req_o.wdata.size = ms_q;
          state_d              = ST_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
          if (p_q < cnt_q) begin
            mv_rd_d    = IW'(cnt_q - 1'b1);
            mv_last_d  = p_q[IW-1:0];
            mv_up_d    = 1'b1;
            mv_issue_d = 1'b1;
            mv_new_d   = 1'b1;
            state_d    = ST_MOVE;
          end else begin
            state_d = ST_F_WRITE;
          end
        end
      end

      ST_F_WRITE: begin
        tbl_req_o.we         = 1'b1;
        tbl_req_o.waddr      = p_q[IW-1:0];
        tbl_req_o.wdata.hdr  = b_q;
        tbl_req_o.wdata.size = size_q;
        state_d              = ST_DONE;
      end

      // shift a run of entries by one place, read ahead of write
      ST_MOVE: begin
        tbl_req_o.raddr = mv_rd_q;
        if (mv_issue_q) begin
          if (mv_rd_q == mv_last_q) begin
            mv_issue_d = 1'b0;
          end else begin
            mv_rd_d = mv_up_q ? mv_rd_q - 1'b1 : mv_rd_q + 1'b1;
          end
        end
        pend_d = mv_issue_q;
        cidx_d = mv_rd_q;
        if (pend_q) begin
          tbl_req_o.we    = 1'b1;
          tbl_req_o.waddr = mv_up_q ? cidx_q + 1'b1 : cidx_q - 1'b1;
          tbl_req_o.wdata = e;
        end
        if (!mv_issue_q && !pend_q) begin
          state_d = mv_new_q ? ST_F_WRITE : ST_DONE;
        end
      end

      ST_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state, counters and control flags under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cnt_q      <= '0;
      used_q     <= '0;
      pend_q     <= 1'b0;
      mv_issue_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      used_q     <= used_d;
      pend_q     <= pend_d;
      mv_issue_q <= mv_issue_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    size_q       <= size_d;
    b_q          <= b_d;
    rd_q         <= rd_d;
    cidx_q       <= cidx_d;
    best_found_q <= best_found_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    p_q          <= p_d;
    prev_q       <= prev_d;
    prev_valid_q <= prev_valid_d;
    nxt_q        <= nxt_d;
    nxt_valid_q  <= nxt_valid_d;
    rm_q         <= rm_d;
    ms_q         <= ms_d;
    lm_q         <= lm_d;
    lsize_q      <= lsize_d;
    hsum_q       <= hsum_d;
    mv_rd_q      <= mv_rd_d;
    mv_last_q    <= mv_last_d;
    mv_up_q      <= mv_up_d;
    mv_new_q     <= mv_new_d;
    res_addr_q   <= res_addr_d;
    res_size_q   <= res_size_d;
    res_status_q <= res_status_d;
  end

  assign res_addr_o   = res_addr_q;
  assign res_size_o   = res_size_q;
  assign res_status_o = res_status_q;

endmodule

### hw/rtl/bfsa_checker.sv
// ----------------------------------------------------------------------------
// bfsa_checker
// port-level checks on the allocator, attached by bind
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bfsa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [bfsa_pkg::TDATA_W-1:0]  m_axis_tdata,
  input logic [2:0]                    m_axis_tuser
);

  logic s_acc;
  logic no_grant;

  assign s_acc    = s_axis_tvalid && s_axis_tready;
  assign no_grant = m_axis_tvalid && (m_axis_tuser == bfsa_pkg::STAT_FREED ||
                    m_axis_tuser == bfsa_pkg::STAT_EXH || m_axis_tuser == bfsa_pkg::STAT_FULL);

  // one item at a time: busy right after an accept
  `BFSA_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, s_acc, !s_axis_tready)

  // status stays within the defined codes
  `BFSA_ASSERT_IMPL(a_status_range, clk_i, rst_ni, m_axis_tvalid, m_axis_tuser <= bfsa_pkg::STAT_FULL)

  // frees and failures carry no grant
  `BFSA_ASSERT_IMPL(a_zero_grant, clk_i, rst_ni, no_grant, m_axis_tdata == '0)

  // a stalled result holds
  `BFSA_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (.*);
